// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, also during reset
`define ERD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

// Check a property on every rising clock edge outside reset
`define ERD_ASSERT_RUN(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// ===== design/erd_pkg.sv =====
// ----------------------------------------------------------------------------
// erd_pkg
// Shared types and constants of the encoder reply deframer.
// ----------------------------------------------------------------------------
package erd_pkg;

   // Frame layout
   localparam int FRAME_LEN     = 19;
   localparam int CHECK_POS     = 18;
   localparam int SUM_FIRST     = 2;
   localparam int SUM_COUNT     = 16;
   localparam int SLOT_ONE_POS  = 6;
   localparam int SLOT_TWO_POS  = 10;
   localparam int AUX_POS       = 14;
   localparam int HELD_W        = 5;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] REPLY_TAG = 8'h0F;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_MOTOR_ID        = 2'd0,
      CSR_SWAP_WHEELS     = 2'd1,
      CSR_NEGATE_SLOT_ONE = 2'd2,
      CSR_NEGATE_SLOT_TWO = 2'd3
   } erd_csr_index_type;

   typedef struct packed {
      logic [7:0] motor_id;
      logic       swap_wheels;
      logic       negate_slot_one;
      logic       negate_slot_two;
   } erd_cfg_type;

   // Raw counts of one matched frame
   typedef struct packed {
      logic [31:0] slot_one;
      logic [31:0] slot_two;
      logic [31:0] aux;
   } erd_frame_type;

endpackage

// ===== design/encoder_reply_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// encoder_reply_deframer_unit
// Finds encoder reply frames in a received byte stream and reports the
// wheel counts with their deltas since the previous frame.
//
//   Channel  Direction  Handshake                     Carries
//   req_     in         req_valid / req_ready         one received byte
//   rsp_     out        rsp_valid / rsp_ready         counts, deltas, first flag
//   csr      in/out     psel, penable, pwrite, pready four config registers
//
// One byte is taken per cycle; the frame check over the window runs in the
// cycle the byte is taken. Matched frames pass the queue and result register.
// Reset clears the byte count, the queue and the first-frame state.
// A stalled result side backs up into the frame queue; bytes are refused
// only while the queue is full.
// ----------------------------------------------------------------------------
module encoder_reply_deframer_unit
   import erd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_left_ticks,
   output logic signed [31:0] rsp_right_ticks,
   output logic signed [31:0] rsp_aux_ticks,
   output logic signed [31:0] rsp_left_delta,
   output logic signed [31:0] rsp_right_delta,
   output logic               rsp_first_frame,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   erd_cfg_type       cfg_ff;
   erd_cfg_type       cfg_in;
   erd_csr_index_type csr_index;
   logic              csr_write;
   logic              push_valid;
   logic              push_ready;
   erd_frame_type     push_data;
   logic              pop_valid;
   logic              pop_ready;
   erd_frame_type     pop_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = erd_csr_index_type'(paddr[3:2]);

   // Write the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MOTOR_ID:        cfg_in.motor_id        = pwdata[7:0];
            CSR_SWAP_WHEELS:     cfg_in.swap_wheels     = pwdata[0];
            CSR_NEGATE_SLOT_ONE: cfg_in.negate_slot_one = pwdata[0];
            CSR_NEGATE_SLOT_TWO: cfg_in.negate_slot_two = pwdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (csr_index)
         CSR_MOTOR_ID:        prdata = {24'd0, cfg_ff.motor_id};
         CSR_SWAP_WHEELS:     prdata = {31'd0, cfg_ff.swap_wheels};
         CSR_NEGATE_SLOT_ONE: prdata = {31'd0, cfg_ff.negate_slot_one};
         CSR_NEGATE_SLOT_TWO: prdata = {31'd0, cfg_ff.negate_slot_two};
         default:             prdata = '0;
      endcase
   end

   erd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   erd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   erd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_ticks  (rsp_left_ticks),
      .rsp_right_ticks (rsp_right_ticks),
      .rsp_aux_ticks   (rsp_aux_ticks),
      .rsp_left_delta  (rsp_left_delta),
      .rsp_right_delta (rsp_right_delta),
      .rsp_first_frame (rsp_first_frame)
   );

endmodule

// ===== design/erd_front.sv =====
// ----------------------------------------------------------------------------
// erd_front
// Byte window, frame detection and extraction of the raw counts.
// ----------------------------------------------------------------------------
module erd_front
   import erd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  erd_cfg_type   cfg,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_rx_byte,
   output logic          push_valid,
   input  logic          push_ready,
   output erd_frame_type push_data
);

   localparam logic [HELD_W-1:0] HELD_FULL = HELD_W'(FRAME_LEN - 1);

   logic [7:0]        window_ff [FRAME_LEN];
   logic [7:0]        window_in [FRAME_LEN];
   logic [HELD_W-1:0] held_ff;
   logic [HELD_W-1:0] held_in;
   logic [7:0]        sum_l1 [8];
   logic [7:0]        sum_l2 [4];
   logic [7:0]        sum_l3 [2];
   logic [7:0]        sum_all;
   logic              header_ok;
   logic              is_frame;
   logic              accept;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   // Shift the new item in at the top; the window always holds the last bytes
   always_comb begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
         window_in[i] = window_ff[i + 1];
      end
      window_in[FRAME_LEN - 1] = req_rx_byte;
   end

   // Checksum tree over frame bytes two to seventeen of the shifted window
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         sum_l1[i] = window_ff[SUM_FIRST + 1 + 2 * i] + window_ff[SUM_FIRST + 2 + 2 * i];
      end
      for (int i = 0; i < 4; i++) begin
         sum_l2[i] = sum_l1[2 * i] + sum_l1[2 * i + 1];
      end
      for (int i = 0; i < 2; i++) begin
         sum_l3[i] = sum_l2[2 * i] + sum_l2[2 * i + 1];
      end
      sum_all = sum_l3[0] + sum_l3[1];
   end

   // Header bytes of the shifted window sit one place higher in the register
   assign header_ok = (window_ff[1] == SYNC_BYTE) && (window_ff[2] == SYNC_BYTE) &&
                      (window_ff[3] == cfg.motor_id) && (window_ff[4] == REPLY_TAG);
   assign is_frame  = (held_ff == HELD_FULL) && header_ok && (~sum_all == req_rx_byte);

   // Pick the little-endian counts out of the shifted window
   assign push_valid = accept && is_frame;
   assign push_data.slot_one = {window_ff[SLOT_ONE_POS + 4], window_ff[SLOT_ONE_POS + 3],
                                window_ff[SLOT_ONE_POS + 2], window_ff[SLOT_ONE_POS + 1]};
   assign push_data.slot_two = {window_ff[SLOT_TWO_POS + 4], window_ff[SLOT_TWO_POS + 3],
                                window_ff[SLOT_TWO_POS + 2], window_ff[SLOT_TWO_POS + 1]};
   assign push_data.aux      = {window_in[AUX_POS + 3], window_in[AUX_POS + 2],
                                window_in[AUX_POS + 1], window_in[AUX_POS]};

   // Empty the window on a frame, hold at full on a mismatch, else count up
   always_comb begin
      held_in = held_ff;
      if (accept) begin
         if (is_frame) begin
            held_in = '0;
         end else if (held_ff != HELD_FULL) begin
            held_in = held_ff + HELD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   // Advance the byte window
   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

endmodule

// ===== design/erd_queue.sv =====
// ----------------------------------------------------------------------------
// erd_queue
// Small first-in first-out queue of matched frames between front and back.
// ----------------------------------------------------------------------------
module erd_queue
   import erd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  erd_frame_type push_data,
   output logic          pop_valid,
   input  logic          pop_ready,
   output erd_frame_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   erd_frame_type     store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/erd_back.sv =====
// ----------------------------------------------------------------------------
// erd_back
// Sign and swap of the wheel counts, deltas and the result register.
// ----------------------------------------------------------------------------
module erd_back
   import erd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  erd_cfg_type        cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  erd_frame_type      pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_left_ticks,
   output logic signed [31:0] rsp_right_ticks,
   output logic signed [31:0] rsp_aux_ticks,
   output logic signed [31:0] rsp_left_delta,
   output logic signed [31:0] rsp_right_delta,
   output logic               rsp_first_frame
);

   logic        valid_ff;
   logic        valid_in;
   logic        have_prev_ff;
   logic        have_prev_in;
   logic [31:0] prev_left_ff;
   logic [31:0] prev_right_ff;
   logic [31:0] left_ff;
   logic [31:0] right_ff;
   logic [31:0] aux_ff;
   logic [31:0] dleft_ff;
   logic [31:0] dright_ff;
   logic        first_ff;
   logic [31:0] slot_one;
   logic [31:0] slot_two;
   logic [31:0] left;
   logic [31:0] right;
   logic        load;

   // Load a new item when the result register is empty or being taken
   assign load      = pop_valid && (!valid_ff || rsp_ready);
   assign pop_ready = !valid_ff || rsp_ready;

   // Apply optional negation, then map slots to wheels
   assign slot_one = cfg.negate_slot_one ? (32'd0 - pop_data.slot_one) : pop_data.slot_one;
   assign slot_two = cfg.negate_slot_two ? (32'd0 - pop_data.slot_two) : pop_data.slot_two;
   assign left     = cfg.swap_wheels ? slot_two : slot_one;
   assign right    = cfg.swap_wheels ? slot_one : slot_two;

   always_comb begin
      valid_in     = valid_ff;
      have_prev_in = have_prev_ff;
      if (load) begin
         valid_in     = 1'b1;
         have_prev_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         have_prev_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         have_prev_ff <= have_prev_in;
      end
   end

   // Capture the result and remember the counts for the next delta
   always_ff @(posedge clock) begin
      if (load) begin
         left_ff       <= left;
         right_ff      <= right;
         aux_ff        <= pop_data.aux;
         dleft_ff      <= have_prev_ff ? (left - prev_left_ff) : 32'd0;
         dright_ff     <= have_prev_ff ? (right - prev_right_ff) : 32'd0;
         first_ff      <= !have_prev_ff;
         prev_left_ff  <= left;
         prev_right_ff <= right;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_left_ticks  = $signed(left_ff);
   assign rsp_right_ticks = $signed(right_ff);
   assign rsp_aux_ticks   = $signed(aux_ff);
   assign rsp_left_delta  = $signed(dleft_ff);
   assign rsp_right_delta = $signed(dright_ff);
   assign rsp_first_frame = first_ff;

endmodule

// ===== design/erd_checker.sv =====
// ----------------------------------------------------------------------------
// erd_checker
// Port-level checks of the encoder reply deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module erd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_first_frame,
   input logic signed [31:0] rsp_left_delta,
   input logic signed [31:0] rsp_right_delta
);

   // Hold a pending item until it is taken
   `ERD_ASSERT_RUN(a_rsp_hold, (rsp_valid && !rsp_ready) |=> rsp_valid, "rsp item dropped")

   // Come out of reset empty and ready for bytes
   `ERD_ASSERT_ALWAYS(a_reset_clear, reset |=> (!rsp_valid && req_ready), "not clear after reset")

   // First frame reports zero deltas
   `ERD_ASSERT_RUN(a_first_zero, (rsp_valid && rsp_first_frame) |-> (rsp_left_delta == 32'sd0 && rsp_right_delta == 32'sd0), "first frame has nonzero delta")

   // After a delivered item no first frame can follow
   `ERD_ASSERT_RUN(a_first_once, (rsp_valid && rsp_ready) |=> !(rsp_valid && rsp_first_frame), "second first frame")

endmodule

bind encoder_reply_deframer_unit erd_checker u_erd_checker (.*);
